>>> src/mrpe_pkg.sv
// Shared types, codes and helpers of the MQTT receive protocol engine.
package mrpe_pkg;

    localparam int MaxResults = 6;
    localparam int QueueDepth = 4;
    localparam logic [15:0] KeepaliveReset = 16'd3000;

    typedef enum logic [1:0] {
        IN_RX_BYTE = 2'd0,
        IN_TICK    = 2'd1,
        IN_OPEN    = 2'd2,
        IN_CLOSE   = 2'd3
    } in_kind_t;

    typedef enum logic [2:0] {
        OK_SEND      = 3'd0,
        OK_TOPIC     = 3'd1,
        OK_PAYLOAD   = 3'd2,
        OK_CONNECTED = 3'd3,
        OK_ABORT     = 3'd4,
        OK_PUBDONE   = 3'd5
    } out_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE       = 2'd0,
        ST_CONNECTING = 2'd1,
        ST_CONNECTED  = 2'd2
    } stage_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LENGTH = 3'd1,
        PH_BODY   = 3'd2
    } phase_t;

    localparam logic [7:0] TypeMask   = 8'hf0;
    localparam logic [7:0] QosMask    = 8'h06;
    localparam logic [7:0] T_CONNACK  = 8'h20;
    localparam logic [7:0] T_PUBLISH  = 8'h30;
    localparam logic [7:0] T_PUBACK   = 8'h40;
    localparam logic [7:0] T_PUBREC   = 8'h50;
    localparam logic [7:0] T_PUBREL   = 8'h60;
    localparam logic [7:0] T_PUBREL_Q = 8'h62;
    localparam logic [7:0] T_PUBCOMP  = 8'h70;
    localparam logic [7:0] T_PINGREQ  = 8'hc0;
    localparam logic [7:0] T_PINGRESP = 8'hd0;

    // One request's worth of results, handed from front to back.
    typedef struct packed {
        logic [2:0]                 count;
        logic [MaxResults-1:0][2:0] kinds;
        logic [MaxResults-1:0][7:0] bytes;
    } cmd_t;

    function automatic cmd_t cmd_push(cmd_t c, logic [2:0] k, logic [7:0] b);
        cmd_t r;
        r = c;
        if (c.count < 3'(MaxResults)) begin
            r.kinds[c.count] = k;
            r.bytes[c.count] = b;
            r.count = c.count + 3'd1;
        end
        return r;
    endfunction

endpackage

>>> src/mrpe_front.sv
// Front end: takes requests, runs the deframer and keepalive, builds result commands.
module mrpe_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                take,
    input  logic [1:0]          kind,
    input  logic [7:0]          rx_byte,
    output logic                cmd_valid,
    output mrpe_pkg::cmd_t      cmd
);

    mrpe_pkg::stage_t stage_reg, stage_next;
    mrpe_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  hb_reg, hb_next;
    logic [15:0] rl_reg, rl_next;
    logic [1:0]  lbc_reg, lbc_next;
    logic [15:0] bc_reg, bc_next;
    logic [15:0] tl_reg, tl_next;
    logic [15:0] mid_reg, mid_next;
    logic [7:0]  rc_reg, rc_next;
    logic        po_reg, po_next;
    logic [15:0] tc_reg, tc_next;
    logic [15:0] lit_reg, lit_next;
    logic [15:0] lot_reg, lot_next;
    logic [15:0] ka_reg;

    always_comb begin
        mrpe_pkg::cmd_t c;
        logic        fin;
        logic        ab;
        logic        sent;
        logic        strm;
        logic        qos_on;
        logic [6:0]  digit;
        logic [15:0] shifted;
        logic [16:0] tl_end;
        logic [15:0] din;
        logic [15:0] dout;
        logic [7:0]  ptype;
        c = '0;
        fin = 1'b0;
        ab = 1'b0;
        sent = 1'b0;
        digit = rx_byte[6:0];
        shifted = '0;
        tl_end = '0;
        din = '0;
        dout = '0;
        ptype = '0;
        stage_next = stage_reg;
        phase_next = phase_reg;
        hb_next = hb_reg;
        rl_next = rl_reg;
        lbc_next = lbc_reg;
        bc_next = bc_reg;
        tl_next = tl_reg;
        mid_next = mid_reg;
        rc_next = rc_reg;
        po_next = po_reg;
        tc_next = tc_reg;
        lit_next = lit_reg;
        lot_next = lot_reg;
        strm = (stage_reg == mrpe_pkg::ST_CONNECTED)
            && ((hb_reg & mrpe_pkg::TypeMask) == mrpe_pkg::T_PUBLISH);
        qos_on = (hb_reg & mrpe_pkg::QosMask) != 8'h00;
        case (mrpe_pkg::in_kind_t'(kind))
            mrpe_pkg::IN_RX_BYTE: begin
                if (stage_reg != mrpe_pkg::ST_IDLE) begin
                    if (phase_reg == mrpe_pkg::PH_HEADER) begin
                        hb_next = rx_byte;
                        rl_next = '0;
                        lbc_next = '0;
                        phase_next = mrpe_pkg::PH_LENGTH;
                    end else if (phase_reg == mrpe_pkg::PH_LENGTH) begin
                        if (lbc_reg >= 2'd2 && (rx_byte[7] || digit > 7'd3)) begin
                            ab = 1'b1;
                        end else begin
                            case (lbc_reg)
                                2'd0:    shifted = {9'd0, digit};
                                2'd1:    shifted = {2'd0, digit, 7'd0};
                                default: shifted = {digit[1:0], 14'd0};
                            endcase
                            rl_next = rl_reg + shifted;
                            if (rx_byte[7]) begin
                                lbc_next = lbc_reg + 2'd1;
                            end else begin
                                phase_next = mrpe_pkg::PH_BODY;
                                bc_next = '0;
                                tl_next = '0;
                                rc_next = '0;
                                if (strm && rl_next < (qos_on ? 16'd4 : 16'd2)) begin
                                    ab = 1'b1;
                                end else if (rl_next == 16'd0) begin
                                    fin = 1'b1;
                                end
                            end
                        end
                    end else begin
                        bc_next = bc_reg + 16'd1;
                        tl_end = 17'd2 + {1'b0, tl_reg};
                        if (strm) begin
                            if (bc_reg == 16'd0) begin
                                tl_next = {rx_byte, 8'd0};
                            end else if (bc_reg == 16'd1) begin
                                tl_next = tl_reg | {8'd0, rx_byte};
                                if ({1'b0, rl_reg} < 17'd2 + (qos_on ? 17'd2 : 17'd0)
                                        + {1'b0, tl_next}) begin
                                    ab = 1'b1;
                                end
                            end else if ({1'b0, bc_reg} < tl_end) begin
                                c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_TOPIC, rx_byte);
                            end else if (qos_on && {1'b0, bc_reg} == tl_end) begin
                                mid_next = {rx_byte, 8'd0};
                            end else if (qos_on && {1'b0, bc_reg} == tl_end + 17'd1) begin
                                mid_next = mid_reg | {8'd0, rx_byte};
                            end else begin
                                c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_PAYLOAD, rx_byte);
                            end
                        end else begin
                            if (bc_reg == 16'd0) begin
                                mid_next = {rx_byte, 8'd0};
                            end else if (bc_reg == 16'd1) begin
                                mid_next = mid_reg | {8'd0, rx_byte};
                                rc_next = rx_byte;
                            end
                        end
                        if (!ab && bc_next == rl_reg) begin
                            fin = 1'b1;
                        end
                    end
                end
            end
            mrpe_pkg::IN_TICK: begin
                tc_next = tc_reg + 16'd1;
                din = tc_next - lit_reg;
                dout = tc_next - lot_reg;
                if (stage_reg == mrpe_pkg::ST_CONNECTED) begin
                    if (din > ka_reg || dout > ka_reg) begin
                        if (po_reg) begin
                            ab = 1'b1;
                        end else begin
                            c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_SEND, mrpe_pkg::T_PINGREQ);
                            c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_SEND, 8'h00);
                            sent = 1'b1;
                            lit_next = tc_next;
                            po_next = 1'b1;
                        end
                    end
                end else if (stage_reg == mrpe_pkg::ST_CONNECTING) begin
                    if (din > ka_reg) begin
                        ab = 1'b1;
                    end
                end
            end
            mrpe_pkg::IN_OPEN: begin
                phase_next = mrpe_pkg::PH_HEADER;
                hb_next = '0;
                rl_next = '0;
                lbc_next = '0;
                bc_next = '0;
                tl_next = '0;
                rc_next = '0;
                mid_next = '0;
                po_next = 1'b0;
                lit_next = tc_reg;
                lot_next = tc_reg;
                stage_next = mrpe_pkg::ST_CONNECTING;
            end
            default: begin
                stage_next = mrpe_pkg::ST_IDLE;
                phase_next = mrpe_pkg::PH_HEADER;
                hb_next = '0;
                rl_next = '0;
                lbc_next = '0;
                bc_next = '0;
                tl_next = '0;
                rc_next = '0;
            end
        endcase

        if (fin) begin
            ptype = hb_next & mrpe_pkg::TypeMask;
            lit_next = tc_next;
            phase_next = mrpe_pkg::PH_HEADER;
            if (stage_reg == mrpe_pkg::ST_CONNECTING) begin
                if (ptype != mrpe_pkg::T_CONNACK || rl_next < 16'd2 || rc_next != 8'd0) begin
                    ab = 1'b1;
                end else begin
                    stage_next = mrpe_pkg::ST_CONNECTED;
                    c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_CONNECTED, 8'h00);
                end
            end else if (stage_reg == mrpe_pkg::ST_CONNECTED) begin
                case (ptype)
                    mrpe_pkg::T_PUBLISH: begin
                        c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_PUBDONE, 8'h00);
                        if (hb_next[2:1] == 2'd1 || hb_next[2:1] == 2'd2) begin
                            c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_SEND,
                                hb_next[2:1] == 2'd1 ? mrpe_pkg::T_PUBACK
                                                     : mrpe_pkg::T_PUBREC);
                            c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_SEND, 8'h02);
                            c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_SEND, mid_next[15:8]);
                            c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_SEND, mid_next[7:0]);
                            sent = 1'b1;
                        end
                    end
                    mrpe_pkg::T_PUBREC, mrpe_pkg::T_PUBREL: begin
                        if (rl_next < 16'd2) begin
                            ab = 1'b1;
                        end else begin
                            c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_SEND,
                                ptype == mrpe_pkg::T_PUBREC ? mrpe_pkg::T_PUBREL_Q
                                                            : mrpe_pkg::T_PUBCOMP);
                            c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_SEND, 8'h02);
                            c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_SEND, mid_next[15:8]);
                            c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_SEND, mid_next[7:0]);
                            sent = 1'b1;
                        end
                    end
                    mrpe_pkg::T_PINGREQ: begin
                        c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_SEND, mrpe_pkg::T_PINGRESP);
                        c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_SEND, 8'h00);
                        sent = 1'b1;
                    end
                    mrpe_pkg::T_PINGRESP: begin
                        po_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (ab) begin
            c = mrpe_pkg::cmd_push(c, mrpe_pkg::OK_ABORT, 8'h00);
            stage_next = mrpe_pkg::ST_IDLE;
            phase_next = mrpe_pkg::PH_HEADER;
            hb_next = '0;
            rl_next = '0;
            lbc_next = '0;
            bc_next = '0;
            tl_next = '0;
            rc_next = '0;
        end
        if (sent) begin
            lot_next = tc_next;
        end
        cmd = c;
        cmd_valid = take && (c.count != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= mrpe_pkg::ST_IDLE;
            phase_reg <= mrpe_pkg::PH_HEADER;
            hb_reg <= '0;
            rl_reg <= '0;
            lbc_reg <= '0;
            bc_reg <= '0;
            tl_reg <= '0;
            mid_reg <= '0;
            rc_reg <= '0;
            po_reg <= 1'b0;
            tc_reg <= '0;
            lit_reg <= '0;
            lot_reg <= '0;
            ka_reg <= mrpe_pkg::KeepaliveReset;
        end else begin
            if (cfg_wr_en) begin
                ka_reg <= cfg_wr_data;
            end
            if (take) begin
                stage_reg <= stage_next;
                phase_reg <= phase_next;
                hb_reg <= hb_next;
                rl_reg <= rl_next;
                lbc_reg <= lbc_next;
                bc_reg <= bc_next;
                tl_reg <= tl_next;
                mid_reg <= mid_next;
                rc_reg <= rc_next;
                po_reg <= po_next;
                tc_reg <= tc_next;
                lit_reg <= lit_next;
                lot_reg <= lot_next;
            end
        end
    end

endmodule

>>> src/mrpe_queue.sv
// Short command queue between front and back.
module mrpe_queue #(
    parameter int DEPTH = mrpe_pkg::QueueDepth
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mrpe_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output mrpe_pkg::cmd_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mrpe_pkg::cmd_t        mem_reg [DEPTH];
    logic [PW-1:0]         wr_reg, rd_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  do_pop;

    assign full = cnt_reg == CW'(DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head = mem_reg[rd_reg];
    assign do_pop = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(do_pop);
        end
    end

endmodule

>>> src/mrpe_back.sv
// Back end: plays out the queue head's results, one per cycle if m_ready is high.
module mrpe_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  mrpe_pkg::cmd_t head,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [2:0]     m_out_kind,
    output logic [7:0]     m_out_byte,
    output logic           m_last
);

    logic [2:0] idx_reg;

    assign m_valid = head_valid;
    assign m_out_kind = head.kinds[idx_reg];
    assign m_out_byte = head.bytes[idx_reg];
    assign m_last = idx_reg == head.count - 3'd1;
    assign pop = m_valid && m_ready && m_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            idx_reg <= m_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

endmodule

>>> src/mqtt_receive_protocol_engine.sv
// Throughput: one request per cycle while the command queue has room; the
// result port plays out one result per cycle while m_ready is high, up to
// six per request, after those of earlier requests.
// Reset (aresetn low, synchronous) idles the connection, clears the parser,
// timers and queue, and sets the keepalive period to 3000 ticks.
module mqtt_receive_protocol_engine #(
    parameter int QUEUE_DEPTH = mrpe_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);

    logic           full, take, cmd_valid, pop, head_valid;
    mrpe_pkg::cmd_t cmd, head;

    assign s_ready = !full;
    assign take = s_valid && s_ready;

    mrpe_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .take(take), .kind(s_kind), .rx_byte(s_rx_byte),
        .cmd_valid(cmd_valid), .cmd(cmd)
    );

    mrpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(cmd_valid), .push_data(cmd), .full(full),
        .pop(pop), .head_valid(head_valid), .head(head)
    );

    mrpe_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .head_valid(head_valid), .head(head), .pop(pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_kind(m_out_kind), .m_out_byte(m_out_byte), .m_last(m_last)
    );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the MQTT receive protocol engine.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_out_kind;
    logic [7:0]  m_out_byte;
    logic        m_last;

    mqtt_receive_protocol_engine u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_rx_byte(s_rx_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_kind(m_out_kind),
        .m_out_byte(m_out_byte), .m_last(m_last)
    );

    always #2 aclk = ~aclk;

    // Expected results and test control.
    result_t expected_results[$];
    result_t step_results[$];
    int      error_count = 0;
    int      item_count = 0;
    bit      no_idle = 1'b0;
    bit      hold_req = 1'b0;

    // Shadow of the engine state.
    logic [15:0]       keepalive;
    mrpe_pkg::stage_t  stage_q;
    mrpe_pkg::phase_t  phase_q;
    logic [7:0]  hdr_q;
    logic [15:0] rem_len, body_cnt, topic_len, msg_id;
    logic [15:0] ticks, last_in, last_out;
    logic [1:0]  len_cnt;
    logic [7:0]  ret_code;
    logic        ping_out;

    task automatic push_result(logic [2:0] k, logic [7:0] b);
        result_t r;
        if (step_results.size() < mrpe_pkg::MaxResults) begin
            r.kind = k;
            r.data = b;
            r.last = 1'b0;
            step_results.push_back(r);
            if (k == mrpe_pkg::OK_SEND) last_out = ticks;
        end
    endtask

    task automatic clear_parser();
        phase_q = mrpe_pkg::PH_HEADER;
        hdr_q = '0;
        rem_len = '0;
        len_cnt = '0;
        body_cnt = '0;
        topic_len = '0;
        ret_code = '0;
    endtask

    task automatic abort_conn();
        push_result(mrpe_pkg::OK_ABORT, 8'h00);
        stage_q = mrpe_pkg::ST_IDLE;
        clear_parser();
    endtask

    task automatic push_ack(logic [7:0] h);
        push_result(mrpe_pkg::OK_SEND, h);
        push_result(mrpe_pkg::OK_SEND, 8'h02);
        push_result(mrpe_pkg::OK_SEND, msg_id[15:8]);
        push_result(mrpe_pkg::OK_SEND, msg_id[7:0]);
    endtask

    task automatic end_of_packet();
        logic [7:0] ptype;
        logic [1:0] qos;
        ptype = hdr_q & mrpe_pkg::TypeMask;
        qos = 2'((hdr_q & mrpe_pkg::QosMask) >> 1);
        last_in = ticks;
        phase_q = mrpe_pkg::PH_HEADER;
        if (stage_q == mrpe_pkg::ST_CONNECTING) begin
            if (ptype != mrpe_pkg::T_CONNACK || rem_len < 16'd2 || ret_code != 8'h00) begin
                abort_conn();
            end else begin
                stage_q = mrpe_pkg::ST_CONNECTED;
                push_result(mrpe_pkg::OK_CONNECTED, 8'h00);
            end
        end else if (stage_q == mrpe_pkg::ST_CONNECTED) begin
            case (ptype)
                mrpe_pkg::T_PUBLISH: begin
                    push_result(mrpe_pkg::OK_PUBDONE, 8'h00);
                    if (qos == 2'd1) push_ack(mrpe_pkg::T_PUBACK);
                    else if (qos == 2'd2) push_ack(mrpe_pkg::T_PUBREC);
                end
                mrpe_pkg::T_PUBREC: begin
                    if (rem_len < 16'd2) abort_conn();
                    else push_ack(mrpe_pkg::T_PUBREL_Q);
                end
                mrpe_pkg::T_PUBREL: begin
                    if (rem_len < 16'd2) abort_conn();
                    else push_ack(mrpe_pkg::T_PUBCOMP);
                end
                mrpe_pkg::T_PINGREQ: begin
                    push_result(mrpe_pkg::OK_SEND, mrpe_pkg::T_PINGRESP);
                    push_result(mrpe_pkg::OK_SEND, 8'h00);
                end
                mrpe_pkg::T_PINGRESP: ping_out = 1'b0;
                default: ;
            endcase
        end
    endtask

    task automatic take_body_byte(logic [7:0] b);
        int idx;
        int extra;
        bit aborted;
        idx = body_cnt;
        aborted = 1'b0;
        body_cnt = body_cnt + 16'd1;
        if (stage_q == mrpe_pkg::ST_CONNECTED
                && (hdr_q & mrpe_pkg::TypeMask) == mrpe_pkg::T_PUBLISH) begin
            extra = ((hdr_q & mrpe_pkg::QosMask) != 0) ? 2 : 0;
            if (idx == 0) begin
                topic_len = {b, 8'h00};
            end else if (idx == 1) begin
                topic_len = topic_len | {8'h00, b};
                if (int'(rem_len) < 2 + extra + int'(topic_len)) begin
                    abort_conn();
                    aborted = 1'b1;
                end
            end else if (idx < 2 + int'(topic_len)) begin
                push_result(mrpe_pkg::OK_TOPIC, b);
            end else if (extra != 0 && idx == 2 + int'(topic_len)) begin
                msg_id = {b, 8'h00};
            end else if (extra != 0 && idx == 3 + int'(topic_len)) begin
                msg_id = msg_id | {8'h00, b};
            end else begin
                push_result(mrpe_pkg::OK_PAYLOAD, b);
            end
        end else if (idx == 0) begin
            msg_id = {b, 8'h00};
        end else if (idx == 1) begin
            msg_id = msg_id | {8'h00, b};
            ret_code = b;
        end
        if (!aborted && body_cnt == rem_len) end_of_packet();
    endtask

    task automatic take_length_byte(logic [7:0] b);
        logic [31:0] digit;
        logic [31:0] acc;
        digit = {25'd0, b[6:0]};
        if (len_cnt >= 2'd2 && (b[7] || digit > 32'd3)) begin
            abort_conn();
        end else begin
            acc = {16'd0, rem_len} + (digit << (7 * len_cnt));
            rem_len = acc[15:0];
            if (b[7]) begin
                len_cnt = len_cnt + 2'd1;
            end else begin
                phase_q = mrpe_pkg::PH_BODY;
                body_cnt = '0;
                topic_len = '0;
                ret_code = '0;
                if (stage_q == mrpe_pkg::ST_CONNECTED
                        && (hdr_q & mrpe_pkg::TypeMask) == mrpe_pkg::T_PUBLISH
                        && rem_len < (((hdr_q & mrpe_pkg::QosMask) != 0) ? 16'd4 : 16'd2))
                begin
                    abort_conn();
                end else if (rem_len == 16'd0) begin
                    end_of_packet();
                end
            end
        end
    endtask

    task automatic take_tick();
        logic [15:0] din, dout;
        ticks = ticks + 16'd1;
        din = ticks - last_in;
        dout = ticks - last_out;
        if (stage_q == mrpe_pkg::ST_CONNECTED) begin
            if (din > keepalive || dout > keepalive) begin
                if (ping_out) begin
                    abort_conn();
                end else begin
                    push_result(mrpe_pkg::OK_SEND, mrpe_pkg::T_PINGREQ);
                    push_result(mrpe_pkg::OK_SEND, 8'h00);
                    last_in = ticks;
                    ping_out = 1'b1;
                end
            end
        end else if (stage_q == mrpe_pkg::ST_CONNECTING && din > keepalive) begin
            abort_conn();
        end
    endtask

    // Advances the shadow state by one accepted request and queues its results.
    task automatic engine_step(logic [1:0] k, logic [7:0] b);
        step_results.delete();
        case (mrpe_pkg::in_kind_t'(k))
            mrpe_pkg::IN_RX_BYTE: begin
                if (stage_q != mrpe_pkg::ST_IDLE) begin
                    if (phase_q == mrpe_pkg::PH_HEADER) begin
                        hdr_q = b;
                        rem_len = '0;
                        len_cnt = '0;
                        phase_q = mrpe_pkg::PH_LENGTH;
                    end else if (phase_q == mrpe_pkg::PH_LENGTH) begin
                        take_length_byte(b);
                    end else begin
                        take_body_byte(b);
                    end
                end
            end
            mrpe_pkg::IN_TICK: take_tick();
            mrpe_pkg::IN_OPEN: begin
                clear_parser();
                msg_id = '0;
                ping_out = 1'b0;
                last_in = ticks;
                last_out = ticks;
                stage_q = mrpe_pkg::ST_CONNECTING;
            end
            default: begin
                stage_q = mrpe_pkg::ST_IDLE;
                clear_parser();
            end
        endcase
        if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endtask

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                          m_out_kind, m_out_byte));
            end else begin
                e = expected_results.pop_front();
                if (m_out_kind != e.kind || m_out_byte != e.data || m_last != e.last)
                    report_mismatch($sformatf("got kind %0d byte %02h last %0b, want %0d %02h %0b",
                                              m_out_kind, m_out_byte, m_last,
                                              e.kind, e.data, e.last));
            end
        end
    end

    // Result side flow control.
    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
        end
    end

    task automatic send_item(logic [1:0] k, logic [7:0] b);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= k;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        engine_step(k, b);
        item_count++;
    endtask

    task automatic send_packet(logic [7:0] bytes[$]);
        foreach (bytes[i]) send_item(mrpe_pkg::IN_RX_BYTE, bytes[i]);
    endtask

    // Stops offering requests and waits until every expected result is out.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_keepalive(logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        keepalive = v;
    endtask

    task automatic connect();
        send_item(mrpe_pkg::IN_OPEN, 8'h00);
        send_packet('{mrpe_pkg::T_CONNACK, 8'h02, 8'h00, 8'h00});
    endtask

    task automatic test_directed_packets();
        send_item(mrpe_pkg::IN_RX_BYTE, 8'hff);             // ignored while idle
        connect();
        // QoS 1 publish: topic "A", id 0x1234, one payload byte.
        send_packet('{8'h32, 8'h06, 8'h00, 8'h01, 8'h41, 8'h12, 8'h34, 8'hff});
        send_packet('{mrpe_pkg::T_PINGREQ, 8'h00});
        send_packet('{mrpe_pkg::T_PUBREC, 8'h02, 8'h00, 8'h07});
        send_item(mrpe_pkg::IN_TICK, 8'h00);
        send_item(mrpe_pkg::IN_CLOSE, 8'h00);
        // A connack with a nonzero return code is refused.
        send_item(mrpe_pkg::IN_OPEN, 8'h00);
        send_packet('{mrpe_pkg::T_CONNACK, 8'h02, 8'h00, 8'h05});
        // A third length byte with the continuation bit set aborts.
        connect();
        send_packet('{8'h30, 8'hff, 8'hff, 8'hff});
        drain();
    endtask

    task automatic test_keepalive();
        write_keepalive(16'd1);
        connect();
        repeat (6) send_item(mrpe_pkg::IN_TICK, 8'h00);
        send_item(mrpe_pkg::IN_OPEN, 8'h00);
        repeat (3) send_item(mrpe_pkg::IN_TICK, 8'h00);
        drain();
        write_keepalive(16'hffff);
        connect();
        repeat (3) send_item(mrpe_pkg::IN_TICK, 8'h00);
        drain();
    endtask

    task automatic random_packet();
        logic [7:0] pkt[$];
        int sel, qos, tl, pl, len;
        sel = $urandom_range(0, 19);
        pkt.delete();
        if (stage_q == mrpe_pkg::ST_IDLE && $urandom_range(0, 9) != 0) begin
            connect();
            return;
        end
        if (sel < 9) begin
            qos = $urandom_range(0, 3);
            tl = $urandom_range(0, 3);
            pl = $urandom_range(0, 4);
            len = 2 + tl + (qos != 0 ? 2 : 0) + pl;
            pkt.push_back(8'(mrpe_pkg::T_PUBLISH | (qos << 1) | $urandom_range(0, 1)
                             | ($urandom_range(0, 1) << 3)));
            if ($urandom_range(0, 3) == 0) begin
                pkt.push_back(8'(len | 8'h80));
                pkt.push_back(8'h00);
            end else begin
                pkt.push_back(8'(len));
            end
            pkt.push_back(8'h00);
            pkt.push_back(8'(tl));
            repeat (tl + (qos != 0 ? 2 : 0) + pl) pkt.push_back(8'($urandom));
            send_packet(pkt);
        end else if (sel < 14) begin
            case ($urandom_range(0, 4))
                0: pkt.push_back(mrpe_pkg::T_PUBREC);
                1: pkt.push_back(mrpe_pkg::T_PUBREL);
                2: pkt.push_back(mrpe_pkg::T_PUBACK);
                3: pkt.push_back(mrpe_pkg::T_PUBCOMP);
                default: pkt.push_back(mrpe_pkg::T_CONNACK);
            endcase
            len = $urandom_range(0, 4);
            pkt.push_back(8'(len));
            repeat (len) pkt.push_back(8'($urandom));
            send_packet(pkt);
        end else if (sel < 16) begin
            send_packet('{($urandom_range(0, 1) != 0) ? mrpe_pkg::T_PINGREQ
                                                      : mrpe_pkg::T_PINGRESP, 8'h00});
        end else if (sel < 18) begin
            repeat ($urandom_range(1, 4)) send_item(mrpe_pkg::IN_TICK, 8'h00);
        end else if (sel == 18) begin
            repeat ($urandom_range(1, 3)) send_item(2'($urandom), 8'($urandom));
        end else begin
            send_item(mrpe_pkg::IN_CLOSE, 8'($urandom));
        end
    endtask

    task automatic test_random(int count);
        int stop_at;
        stop_at = item_count + count;
        while (item_count < stop_at) random_packet();
        drain();
    endtask

    task automatic test_backpressure();
        connect();
        hold_req = 1'b1;
        repeat (20) send_packet('{mrpe_pkg::T_PINGREQ, 8'h00});
        drain();
    endtask

    initial begin
        stage_q = mrpe_pkg::ST_IDLE;
        clear_parser();
        keepalive = mrpe_pkg::KeepaliveReset;
        msg_id = '0;
        ping_out = 1'b0;
        ticks = '0;
        last_in = '0;
        last_out = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_packets();
        test_keepalive();
        write_keepalive(16'd12);
        test_random(110);
        test_backpressure();
        write_keepalive(16'd40);
        test_random(110);
        no_idle = 1'b1;
        write_keepalive(16'd5);
        test_random(85);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> mqtt_receive_protocol_engine.f
src/mrpe_pkg.sv
src/mrpe_front.sv
src/mrpe_queue.sv
src/mrpe_back.sv
src/mqtt_receive_protocol_engine.sv
dv/testbench.sv
